FILE: src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under reset
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/fts_pkg.sv
// shared types and constants of the thread scheduler
`default_nettype none

package fts_pkg;

    localparam int TID_W       = 4;
    localparam int MAX_THREADS = 1 << TID_W;
    localparam int CNT_W       = TID_W + 1;
    localparam int NUM_HARTS   = 2;
    localparam int HART_W      = 1;
    localparam int REQ_W       = 3;
    localparam int ERR_W       = 2;
    localparam int STAT_W      = 3;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] REG_IDLE_HART0 = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_HART1 = 1'b1;

    localparam logic [TID_W-1:0] IDLE_HART0_RST = 4'd0;
    localparam logic [TID_W-1:0] IDLE_HART1_RST = 4'd1;

    typedef enum logic [STAT_W-1:0] {
        ST_FREE    = 3'd0,
        ST_READY   = 3'd1,
        ST_RUNNING = 3'd2,
        ST_BLOCKED = 3'd3,
        ST_DYING   = 3'd4
    } status_t;

    typedef enum logic [REQ_W-1:0] {
        REQ_CREATE  = 3'd0,
        REQ_START   = 3'd1,
        REQ_YIELD   = 3'd2,
        REQ_BLOCK   = 3'd3,
        REQ_UNBLOCK = 3'd4,
        REQ_EXIT    = 3'd5
    } req_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK      = 2'd0,
        ERR_NO_ID   = 2'd1,
        ERR_TGT     = 2'd2,
        ERR_NO_IDLE = 2'd3
    } err_t;

    typedef enum logic [2:0] {
        SEL_TGT  = 3'd0,
        SEL_IDLE = 3'd1,
        SEL_CUR  = 3'd2,
        SEL_NEXT = 3'd3,
        SEL_ID   = 3'd4
    } addr_sel_t;

    typedef struct packed {
        logic      accept;
        logic      st_rd;
        addr_sel_t st_rd_sel;
        logic      st_wr;
        addr_sel_t st_wr_sel;
        status_t   st_wr_val;
        logic      push;
        addr_sel_t push_sel;
        logic      pop;
        logic      load_next;
        logic      next_q;
        logic      set_cur;
        logic      set_started;
        logic      id_inc;
        logic      set_new;
        logic      set_switched;
        logic      set_freed;
        logic      set_err;
        err_t      err;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        req_t    req;
        logic    started;
        logic    queue_nz;
        logic    id_full;
        status_t st_rd;
        logic    next_is_cur;
        logic    out_free;
    } sts_t;

endpackage

`default_nettype wire

FILE: src/fts_datapath.sv
// scheduler datapath: status memory, ready queue, hart state, result buffer
`default_nettype none

module fts_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [fts_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [fts_pkg::TID_W-1:0]     cfg_data,
    input  wire logic [fts_pkg::REQ_W-1:0]     req_type,
    input  wire logic [fts_pkg::HART_W-1:0]    hart,
    input  wire logic [fts_pkg::TID_W-1:0]     target_thread,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [fts_pkg::TID_W-1:0]          running_thread,
    output logic                               switched,
    output logic [fts_pkg::TID_W-1:0]          new_thread,
    output logic                               freed_valid,
    output logic [fts_pkg::TID_W-1:0]          freed_thread,
    output logic [fts_pkg::ERR_W-1:0]          error_code,
    input  wire fts_pkg::cmd_t                 cmd,
    output fts_pkg::sts_t                      sts
);

    logic [fts_pkg::TID_W-1:0]   idle_hart0_reg;
    logic [fts_pkg::TID_W-1:0]   idle_hart1_reg;
    fts_pkg::req_t               req_reg;
    logic [fts_pkg::HART_W-1:0]  hart_reg;
    logic [fts_pkg::TID_W-1:0]   tgt_reg;

    fts_pkg::status_t            status_mem [fts_pkg::MAX_THREADS];
    logic [fts_pkg::MAX_THREADS-1:0] status_vld_reg;
    fts_pkg::status_t            status_rd_reg;

    logic [fts_pkg::TID_W-1:0]   fifo_mem [fts_pkg::MAX_THREADS];
    logic [fts_pkg::TID_W-1:0]   fifo_rd_reg;
    logic [fts_pkg::TID_W-1:0]   head_reg;
    logic [fts_pkg::CNT_W-1:0]   count_reg;

    logic [fts_pkg::TID_W-1:0]   cur_reg [fts_pkg::NUM_HARTS];
    logic [fts_pkg::NUM_HARTS-1:0] started_reg;
    logic [fts_pkg::CNT_W-1:0]   idc_reg;
    logic [fts_pkg::TID_W-1:0]   next_reg;

    logic                        sw_reg;
    logic [fts_pkg::TID_W-1:0]   new_reg;
    logic                        fv_reg;
    logic [fts_pkg::TID_W-1:0]   ft_reg;
    fts_pkg::err_t               err_reg;

    logic                        out_valid_reg;
    logic [fts_pkg::TID_W-1:0]   out_run_reg;
    logic                        out_sw_reg;
    logic [fts_pkg::TID_W-1:0]   out_new_reg;
    logic                        out_fv_reg;
    logic [fts_pkg::TID_W-1:0]   out_ft_reg;
    fts_pkg::err_t               out_err_reg;

    logic [fts_pkg::TID_W-1:0]   idle_sel;
    logic [fts_pkg::TID_W-1:0]   cur_sel;
    logic [fts_pkg::TID_W-1:0]   id_sel;
    logic [fts_pkg::TID_W-1:0]   rd_addr;
    logic [fts_pkg::TID_W-1:0]   wr_addr;
    logic [fts_pkg::TID_W-1:0]   push_data;
    logic [fts_pkg::TID_W-1:0]   tail;
    logic                        fifo_full;
    logic                        do_push;

    assign cfg_ready = 1'b1;
    assign idle_sel  = (hart_reg == 1'b1) ? idle_hart1_reg : idle_hart0_reg;
    assign cur_sel   = cur_reg[hart_reg];
    assign id_sel    = idc_reg[fts_pkg::TID_W-1:0];
    assign tail      = head_reg + count_reg[fts_pkg::TID_W-1:0];
    assign fifo_full = count_reg[fts_pkg::TID_W];
    assign do_push   = cmd.push && !fifo_full;

    always_comb
    begin
        case (cmd.st_rd_sel)
            fts_pkg::SEL_TGT:  rd_addr = tgt_reg;
            fts_pkg::SEL_IDLE: rd_addr = idle_sel;
            fts_pkg::SEL_CUR:  rd_addr = cur_sel;
            fts_pkg::SEL_NEXT: rd_addr = next_reg;
            default:           rd_addr = id_sel;
        endcase
        case (cmd.st_wr_sel)
            fts_pkg::SEL_TGT:  wr_addr = tgt_reg;
            fts_pkg::SEL_IDLE: wr_addr = idle_sel;
            fts_pkg::SEL_CUR:  wr_addr = cur_sel;
            fts_pkg::SEL_NEXT: wr_addr = next_reg;
            default:           wr_addr = id_sel;
        endcase
        case (cmd.push_sel)
            fts_pkg::SEL_TGT:  push_data = tgt_reg;
            fts_pkg::SEL_IDLE: push_data = idle_sel;
            fts_pkg::SEL_CUR:  push_data = cur_sel;
            fts_pkg::SEL_NEXT: push_data = next_reg;
            default:           push_data = id_sel;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_hart0_reg <= fts_pkg::IDLE_HART0_RST;
            idle_hart1_reg <= fts_pkg::IDLE_HART1_RST;
            status_vld_reg <= '0;
            head_reg       <= '0;
            count_reg      <= '0;
            for (int i = 0; i < fts_pkg::NUM_HARTS; i++)
            begin
                cur_reg[i] <= '0;
            end
            started_reg    <= '0;
            idc_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    fts_pkg::REG_IDLE_HART0: idle_hart0_reg <= cfg_data;
                    fts_pkg::REG_IDLE_HART1: idle_hart1_reg <= cfg_data;
                endcase
            end
            if (cmd.st_wr)
            begin
                status_vld_reg[wr_addr] <= 1'b1;
            end
            if (cmd.pop)
            begin
                head_reg <= head_reg + 1'b1;
            end
            if (do_push)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (cmd.pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
            if (cmd.set_cur)
            begin
                cur_reg[hart_reg] <= next_reg;
            end
            if (cmd.set_started)
            begin
                started_reg[hart_reg] <= 1'b1;
            end
            if (cmd.id_inc)
            begin
                idc_reg <= idc_reg + 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // memories and payload
    always_ff @(posedge clk)
    begin
        if (cmd.st_wr)
        begin
            status_mem[wr_addr] <= cmd.st_wr_val;
        end
        if (cmd.st_rd)
        begin
            status_rd_reg <= status_vld_reg[rd_addr] ? status_mem[rd_addr] : fts_pkg::ST_FREE;
        end
        if (do_push)
        begin
            fifo_mem[tail] <= push_data;
        end
        if (cmd.pop)
        begin
            fifo_rd_reg <= fifo_mem[head_reg];
        end
        if (cmd.load_next)
        begin
            next_reg <= cmd.next_q ? fifo_rd_reg : idle_sel;
        end
        if (cmd.accept)
        begin
            req_reg  <= fts_pkg::req_t'(req_type);
            hart_reg <= hart;
            tgt_reg  <= target_thread;
            sw_reg   <= 1'b0;
            new_reg  <= '0;
            fv_reg   <= 1'b0;
            ft_reg   <= '0;
            err_reg  <= fts_pkg::ERR_OK;
        end
        else
        begin
            if (cmd.set_switched)
            begin
                sw_reg <= 1'b1;
            end
            if (cmd.set_new)
            begin
                new_reg <= id_sel;
            end
            if (cmd.set_freed)
            begin
                fv_reg <= 1'b1;
                ft_reg <= cur_sel;
            end
            if (cmd.set_err)
            begin
                err_reg <= cmd.err;
            end
        end
        if (cmd.out_load)
        begin
            out_run_reg <= cur_sel;
            out_sw_reg  <= sw_reg;
            out_new_reg <= new_reg;
            out_fv_reg  <= fv_reg;
            out_ft_reg  <= ft_reg;
            out_err_reg <= err_reg;
        end
    end

    always_comb
    begin
        sts.req         = req_reg;
        sts.started     = started_reg[hart_reg];
        sts.queue_nz    = (count_reg != '0);
        sts.id_full     = (idc_reg == fts_pkg::CNT_W'(fts_pkg::MAX_THREADS));
        sts.st_rd       = status_rd_reg;
        sts.next_is_cur = (next_reg == cur_sel);
        sts.out_free    = !out_valid_reg || out_ready;
    end

    assign out_valid      = out_valid_reg;
    assign running_thread = out_run_reg;
    assign switched       = out_sw_reg;
    assign new_thread     = out_new_reg;
    assign freed_valid    = out_fv_reg;
    assign freed_thread   = out_ft_reg;
    assign error_code     = out_err_reg;

endmodule

`default_nettype wire

FILE: src/fts_ctrl.sv
// scheduler controller state machine
`default_nettype none

module fts_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire fts_pkg::sts_t sts,
    output fts_pkg::cmd_t      cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_UNBLK,
        S_PICKQ,
        S_PICKI,
        S_SEL,
        S_LEAVE,
        S_ENTER,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   want_pick;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        case (sts.req)
            fts_pkg::REQ_START: want_pick = !sts.started;
            fts_pkg::REQ_YIELD, fts_pkg::REQ_BLOCK, fts_pkg::REQ_EXIT:
                want_pick = sts.started;
            default: want_pick = 1'b0;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_DONE;
                if (sts.req == fts_pkg::REQ_CREATE)
                begin
                    if (sts.id_full)
                    begin
                        cmd.set_err = 1'b1;
                        cmd.err     = fts_pkg::ERR_NO_ID;
                    end
                    else
                    begin
                        cmd.st_wr     = 1'b1;
                        cmd.st_wr_sel = fts_pkg::SEL_ID;
                        cmd.st_wr_val = fts_pkg::ST_READY;
                        cmd.push      = 1'b1;
                        cmd.push_sel  = fts_pkg::SEL_ID;
                        cmd.set_new   = 1'b1;
                        cmd.id_inc    = 1'b1;
                    end
                end
                else if (sts.req == fts_pkg::REQ_UNBLOCK)
                begin
                    cmd.st_rd     = 1'b1;
                    cmd.st_rd_sel = fts_pkg::SEL_TGT;
                    state_next    = S_UNBLK;
                end
                else if (want_pick)
                begin
                    if (sts.queue_nz)
                    begin
                        cmd.pop    = 1'b1;
                        state_next = S_PICKQ;
                    end
                    else
                    begin
                        cmd.st_rd     = 1'b1;
                        cmd.st_rd_sel = fts_pkg::SEL_IDLE;
                        state_next    = S_PICKI;
                    end
                end
            end
            S_UNBLK:
            begin
                if (sts.st_rd == fts_pkg::ST_BLOCKED)
                begin
                    cmd.st_wr     = 1'b1;
                    cmd.st_wr_sel = fts_pkg::SEL_TGT;
                    cmd.st_wr_val = fts_pkg::ST_READY;
                    cmd.push      = 1'b1;
                    cmd.push_sel  = fts_pkg::SEL_TGT;
                end
                else
                begin
                    cmd.set_err = 1'b1;
                    cmd.err     = fts_pkg::ERR_TGT;
                end
                state_next = S_DONE;
            end
            S_PICKQ:
            begin
                cmd.load_next = 1'b1;
                cmd.next_q    = 1'b1;
                state_next    = S_SEL;
            end
            S_PICKI:
            begin
                if (sts.st_rd == fts_pkg::ST_FREE)
                begin
                    cmd.set_err = 1'b1;
                    cmd.err     = fts_pkg::ERR_NO_IDLE;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.load_next = 1'b1;
                    state_next    = S_SEL;
                end
            end
            S_SEL:
            begin
                if (sts.req == fts_pkg::REQ_START)
                begin
                    cmd.st_wr        = 1'b1;
                    cmd.st_wr_sel    = fts_pkg::SEL_NEXT;
                    cmd.st_wr_val    = fts_pkg::ST_RUNNING;
                    cmd.set_cur      = 1'b1;
                    cmd.set_started  = 1'b1;
                    cmd.set_switched = 1'b1;
                    state_next       = S_DONE;
                end
                else if (sts.next_is_cur)
                begin
                    cmd.st_wr     = 1'b1;
                    cmd.st_wr_sel = fts_pkg::SEL_CUR;
                    cmd.st_wr_val = fts_pkg::ST_RUNNING;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.st_rd     = 1'b1;
                    cmd.st_rd_sel = fts_pkg::SEL_CUR;
                    state_next    = S_LEAVE;
                end
            end
            S_LEAVE:
            begin
                cmd.st_wr_sel = fts_pkg::SEL_CUR;
                if (sts.req == fts_pkg::REQ_BLOCK)
                begin
                    cmd.st_wr     = 1'b1;
                    cmd.st_wr_val = fts_pkg::ST_BLOCKED;
                end
                else if (sts.req == fts_pkg::REQ_EXIT || sts.st_rd == fts_pkg::ST_DYING)
                begin
                    cmd.st_wr     = 1'b1;
                    cmd.st_wr_val = fts_pkg::ST_FREE;
                    cmd.set_freed = 1'b1;
                end
                else if (sts.st_rd == fts_pkg::ST_RUNNING)
                begin
                    cmd.st_wr     = 1'b1;
                    cmd.st_wr_val = fts_pkg::ST_READY;
                    cmd.push      = 1'b1;
                    cmd.push_sel  = fts_pkg::SEL_CUR;
                end
                state_next = S_ENTER;
            end
            S_ENTER:
            begin
                cmd.st_wr        = 1'b1;
                cmd.st_wr_sel    = fts_pkg::SEL_NEXT;
                cmd.st_wr_val    = fts_pkg::ST_RUNNING;
                cmd.set_cur      = 1'b1;
                cmd.set_switched = 1'b1;
                state_next       = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/fifo_thread_scheduler.sv
// thread scheduler top level
//
// channel   dir  handshake              payload
// in        in   in_valid / in_ready    req_type, hart, target_thread
// out       out  out_valid / out_ready  running_thread, switched, new_thread,
//                                       freed_valid, freed_thread, error_code
// cfg       in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one request at a time; yield, block and exit pass through a queue pop or an idle
// thread status read, a status read of the current thread and up to two status writes
// (leave current, enter next), which share the one status write port
// the result sits in an output register, so the next beat is taken while it waits
// reset clears all thread status valid bits at once; no clearing pass
// cfg_ready is always high
`default_nettype none

module fifo_thread_scheduler (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [fts_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [fts_pkg::TID_W-1:0]     cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [fts_pkg::REQ_W-1:0]     req_type,
    input  wire logic [fts_pkg::HART_W-1:0]    hart,
    input  wire logic [fts_pkg::TID_W-1:0]     target_thread,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [fts_pkg::TID_W-1:0]          running_thread,
    output logic                               switched,
    output logic [fts_pkg::TID_W-1:0]          new_thread,
    output logic                               freed_valid,
    output logic [fts_pkg::TID_W-1:0]          freed_thread,
    output logic [fts_pkg::ERR_W-1:0]          error_code
);

    fts_pkg::cmd_t cmd;
    fts_pkg::sts_t sts;

    fts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fts_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .req_type       (req_type),
        .hart           (hart),
        .target_thread  (target_thread),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .running_thread (running_thread),
        .switched       (switched),
        .new_thread     (new_thread),
        .freed_valid    (freed_valid),
        .freed_thread   (freed_thread),
        .error_code     (error_code),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule

`default_nettype wire

FILE: src/fts_checker.sv
// port-level checker for the thread scheduler, bound to the top level
`default_nettype none

`include "assert_macros.svh"

module fts_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      out_valid,
    input wire logic                      out_ready,
    input wire logic [fts_pkg::TID_W-1:0] running_thread,
    input wire logic                      switched,
    input wire logic [fts_pkg::TID_W-1:0] new_thread,
    input wire logic                      freed_valid,
    input wire logic [fts_pkg::TID_W-1:0] freed_thread,
    input wire logic [fts_pkg::ERR_W-1:0] error_code
);

    // stalled result beat stays
    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "out beat dropped while stalled")

    `ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
        $stable(running_thread) && $stable(error_code), "out beat changed while stalled")

    // a failed request has no side effects
    `ASSERT_SAME(a_err_clean, out_valid && error_code != fts_pkg::ERR_OK,
        !switched && new_thread == '0 && !freed_valid, "error beat reports side effects")

    `ASSERT_SAME(a_freed_zero, out_valid && !freed_valid, freed_thread == '0,
        "freed id without release")

endmodule

bind fifo_thread_scheduler fts_checker u_fts_checker (.*);

`default_nettype wire
